/* sv/gpio_ovr_pkg.sv */
// ============================================================================
// gpio_ovr_pkg
// Shared types, codes and helper functions for the GPIO pin override and
// interrupt block.
// ============================================================================
package gpio_ovr_pkg;

    localparam int unsigned CfgIdxW  = 4;
    localparam int unsigned CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] REG_FUNCSEL    = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_OUT_OVR    = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_OE_OVR     = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_IN_OVR     = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_IRQ_OVR    = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_PAD_CTRL   = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_IRQ_ENABLE = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_IRQ_FORCE  = 4'd7;

    localparam logic [1:0] KIND_PAD     = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;

    localparam logic [4:0] FSEL_PWM   = 5'd4;
    localparam logic [4:0] FSEL_SIO   = 5'd5;
    localparam logic [4:0] FSEL_PIO0  = 5'd6;
    localparam logic [4:0] FSEL_PIO1  = 5'd7;
    localparam logic [4:0] FSEL_RESET = 5'd31;

    localparam logic [2:0] PIN_LOW      = 3'd0;
    localparam logic [2:0] PIN_HIGH     = 3'd1;
    localparam logic [2:0] PIN_INPUT    = 3'd2;
    localparam logic [2:0] PIN_PULLDOWN = 3'd3;
    localparam logic [2:0] PIN_PULLUP   = 3'd4;
    localparam logic [2:0] PIN_KEEPER   = 3'd5;

    // Pad control bit positions.
    localparam int unsigned PAD_PULLDOWN_BIT = 2;
    localparam int unsigned PAD_PULLUP_BIT   = 3;
    localparam int unsigned PAD_INEN_BIT     = 6;
    localparam logic [7:0]  PAD_RESET        = 8'h56;

    // Interrupt status bits.
    localparam logic [3:0] STAT_LVL_LO  = 4'b0001;
    localparam logic [3:0] STAT_LVL_HI  = 4'b0010;
    localparam logic [3:0] STAT_EDGE_LO = 4'b0100;
    localparam logic [3:0] STAT_EDGE_HI = 4'b1000;

    typedef enum logic [1:0] {
        OVR_PASS   = 2'd0,
        OVR_INVERT = 2'd1,
        OVR_LOW    = 2'd2,
        OVR_HIGH   = 2'd3
    } ovr_mode_t;

    typedef struct packed {
        logic [4:0] function_select;
        ovr_mode_t  output_override;
        ovr_mode_t  oe_override;
        ovr_mode_t  input_override;
        ovr_mode_t  irq_override;
        logic [7:0] pad_control;
        logic [3:0] irq_enable_mask;
        logic [3:0] irq_force_mask;
    } cfg_t;

    typedef struct packed {
        logic       irq_to_proc;
        logic       irq_from_pad;
        logic       in_to_peri;
        logic       in_from_pad;
        logic       oe_to_pad;
        logic       oe_from_peri;
        logic       out_to_pad;
        logic       out_from_peri;
        logic [2:0] pin_state;
        logic       pin_state_changed;
        logic       irq_changed;
        logic [3:0] irq_status_bits;
    } result_t;

    function automatic logic apply_ovr(input logic v, input ovr_mode_t mode);
        logic r;
        unique case (mode)
            OVR_PASS:   r = v;
            OVR_INVERT: r = ~v;
            OVR_LOW:    r = 1'b0;
            OVR_HIGH:   r = 1'b1;
            default:    r = v;
        endcase
        return r;
    endfunction

    function automatic logic raw_irq(input logic [3:0] status, input cfg_t cfg);
        return |((status & cfg.irq_enable_mask) | cfg.irq_force_mask);
    endfunction

endpackage

/* sv/gpio_ovr_cfg.sv */
// ============================================================================
// gpio_ovr_cfg
// Configuration register file: decodes indexed writes into the pin settings.
// ============================================================================
module gpio_ovr_cfg
    import gpio_ovr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FUNCSEL:    cfg_next.function_select = cfg_wdata[4:0];
                REG_OUT_OVR:    cfg_next.output_override = ovr_mode_t'(cfg_wdata[1:0]);
                REG_OE_OVR:     cfg_next.oe_override     = ovr_mode_t'(cfg_wdata[1:0]);
                REG_IN_OVR:     cfg_next.input_override  = ovr_mode_t'(cfg_wdata[1:0]);
                REG_IRQ_OVR:    cfg_next.irq_override    = ovr_mode_t'(cfg_wdata[1:0]);
                REG_PAD_CTRL:   cfg_next.pad_control     = cfg_wdata;
                REG_IRQ_ENABLE: cfg_next.irq_enable_mask = cfg_wdata[3:0];
                REG_IRQ_FORCE:  cfg_next.irq_force_mask  = cfg_wdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_select <= FSEL_RESET;
            cfg_reg.output_override <= OVR_PASS;
            cfg_reg.oe_override     <= OVR_PASS;
            cfg_reg.input_override  <= OVR_PASS;
            cfg_reg.irq_override    <= OVR_PASS;
            cfg_reg.pad_control     <= PAD_RESET;
            cfg_reg.irq_enable_mask <= '0;
            cfg_reg.irq_force_mask  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/gpio_ovr_core.sv */
// ============================================================================
// gpio_ovr_core
// Pin state registers and the single-pass logic that turns one item into
// one result: peripheral routing, overrides, interrupt status, pin class.
// ============================================================================
module gpio_ovr_core
    import gpio_ovr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [1:0] kind,
    input  logic       pad_level,
    input  logic [3:0] ack_mask,
    input  logic       pwm_oe,
    input  logic       pwm_out,
    input  logic       sio_oe,
    input  logic       sio_out,
    input  logic       pio0_oe,
    input  logic       pio0_out,
    input  logic       pio1_oe,
    input  logic       pio1_out,
    output result_t    res
);

    logic       raw_level_reg;
    logic       raw_level_next;
    logic [3:0] status_reg;
    logic [3:0] status_next;
    logic [2:0] last_state_reg;
    logic [2:0] state_now;

    logic in_en;
    logic oe_peri;
    logic out_peri;
    logic oe_pad;
    logic out_pad;
    logic prev_irq;
    logic irq_now;

    assign in_en = cfg.pad_control[PAD_INEN_BIT];

    always_comb
    begin
        raw_level_next = raw_level_reg;
        status_next    = status_reg;
        case (kind)
            KIND_PAD:
            begin
                raw_level_next = pad_level;
                if (pad_level && in_en)
                    status_next = (status_reg | STAT_EDGE_HI | STAT_LVL_HI)
                                  & ~STAT_LVL_LO;
                else
                    status_next = (status_reg | STAT_EDGE_LO | STAT_LVL_LO)
                                  & ~STAT_LVL_HI;
            end
            KIND_ACK:
                status_next = status_reg & ~(ack_mask & (STAT_EDGE_LO | STAT_EDGE_HI));
            default:
                status_next = status_reg;
        endcase
    end

    always_comb
    begin
        unique case (cfg.function_select)
            FSEL_PWM:
            begin
                oe_peri  = pwm_oe;
                out_peri = pwm_out;
            end
            FSEL_SIO:
            begin
                oe_peri  = sio_oe;
                out_peri = sio_out;
            end
            FSEL_PIO0:
            begin
                oe_peri  = pio0_oe;
                out_peri = pio0_out;
            end
            FSEL_PIO1:
            begin
                oe_peri  = pio1_oe;
                out_peri = pio1_out;
            end
            default:
            begin
                oe_peri  = 1'b0;
                out_peri = 1'b0;
            end
        endcase
    end

    assign oe_pad   = apply_ovr(oe_peri, cfg.oe_override);
    assign out_pad  = apply_ovr(out_peri, cfg.output_override);
    assign prev_irq = apply_ovr(raw_irq(status_reg, cfg), cfg.irq_override);
    assign irq_now  = apply_ovr(raw_irq(status_next, cfg), cfg.irq_override);

    always_comb
    begin
        if (oe_pad)
            state_now = out_pad ? PIN_HIGH : PIN_LOW;
        else if (cfg.pad_control[PAD_PULLDOWN_BIT] && cfg.pad_control[PAD_PULLUP_BIT])
            state_now = PIN_KEEPER;
        else if (cfg.pad_control[PAD_PULLDOWN_BIT])
            state_now = PIN_PULLDOWN;
        else if (cfg.pad_control[PAD_PULLUP_BIT])
            state_now = PIN_PULLUP;
        else
            state_now = PIN_INPUT;
    end

    always_comb
    begin
        res.irq_to_proc       = irq_now;
        res.irq_from_pad      = raw_irq(status_next, cfg);
        res.in_to_peri        = apply_ovr(raw_level_next & in_en, cfg.input_override);
        res.in_from_pad       = raw_level_next;
        res.oe_to_pad         = oe_pad;
        res.oe_from_peri      = oe_peri;
        res.out_to_pad        = out_pad;
        res.out_from_peri     = out_peri;
        res.pin_state         = state_now;
        res.pin_state_changed = (state_now != last_state_reg);
        res.irq_changed       = (irq_now != prev_irq);
        res.irq_status_bits   = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg  <= 1'b0;
            status_reg     <= '0;
            last_state_reg <= PIN_INPUT;
        end
        else if (accept)
        begin
            raw_level_reg  <= raw_level_next;
            status_reg     <= status_next;
            last_state_reg <= state_now;
        end
    end

endmodule

/* sv/gpio_pin_override_and_irq_top.sv */
// ============================================================================
// gpio_pin_override_and_irq_top
// One GPIO pin with peripheral routing, four overrides, sticky interrupt
// status and a pin state classifier behind valid/ready channels.
// ============================================================================
//
//   Channel   Handshake                 Carries
//   -------   -----------------------   ------------------------------------
//   input     in_valid / in_ready       kind, pad level, ack mask, periph bits
//   output    out_valid / out_ready     status bits, pin state, change flags
//   config    cfg_we (no wait)          cfg_index, cfg_wdata
//
// The pin state registers update and the result register loads at the same
// edge as the input is accepted, so the result is offered in the next cycle.
// One input transaction is accepted per cycle as long as the result register
// is empty or being drained in that cycle. A stall on the output holds the
// result and stops input acceptance until it is taken. Reset clears the pin
// state and loads configuration defaults; the block is ready as soon as
// reset is released.
//
module gpio_pin_override_and_irq_top
    import gpio_ovr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic                pad_level,
    input  logic [3:0]          ack_mask,
    input  logic                pwm_oe,
    input  logic                pwm_out,
    input  logic                sio_oe,
    input  logic                sio_out,
    input  logic                pio0_oe,
    input  logic                pio0_out,
    input  logic                pio1_oe,
    input  logic                pio1_out,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                irq_to_proc,
    output logic                irq_from_pad,
    output logic                in_to_peri,
    output logic                in_from_pad,
    output logic                oe_to_pad,
    output logic                oe_from_peri,
    output logic                out_to_pad,
    output logic                out_from_peri,
    output logic [2:0]          pin_state,
    output logic                pin_state_changed,
    output logic                irq_changed,
    output logic [3:0]          irq_status_bits
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    accept;

    // The result register can take a new transaction when it is empty or
    // when its current contents leave in this same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    gpio_ovr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gpio_ovr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .kind      (kind),
        .pad_level (pad_level),
        .ack_mask  (ack_mask),
        .pwm_oe    (pwm_oe),
        .pwm_out   (pwm_out),
        .sio_oe    (sio_oe),
        .sio_out   (sio_out),
        .pio0_oe   (pio0_oe),
        .pio0_out  (pio0_out),
        .pio1_oe   (pio1_oe),
        .pio1_out  (pio1_out),
        .res       (res)
    );

    // The valid flag is control state and is reset; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid         = out_valid_reg;
    assign irq_to_proc       = res_reg.irq_to_proc;
    assign irq_from_pad      = res_reg.irq_from_pad;
    assign in_to_peri        = res_reg.in_to_peri;
    assign in_from_pad       = res_reg.in_from_pad;
    assign oe_to_pad         = res_reg.oe_to_pad;
    assign oe_from_peri      = res_reg.oe_from_peri;
    assign out_to_pad        = res_reg.out_to_pad;
    assign out_from_peri     = res_reg.out_from_peri;
    assign pin_state         = res_reg.pin_state;
    assign pin_state_changed = res_reg.pin_state_changed;
    assign irq_changed       = res_reg.irq_changed;
    assign irq_status_bits   = res_reg.irq_status_bits;

endmodule

/* sv/gpio_ovr_checker.sv */
// ============================================================================
// gpio_ovr_checker
// Port-level checks on the GPIO pin block, bound to the top level.
// ============================================================================
module gpio_ovr_checker
    import gpio_ovr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] kind,
    input logic       pad_level,
    input logic       out_valid,
    input logic       out_ready,
    input logic       in_from_pad,
    input logic       oe_to_pad,
    input logic       out_to_pad,
    input logic [2:0] pin_state,
    input logic [3:0] irq_status_bits
);

    // A stalled result keeps its pin state.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_state))
        else $error("stalled result changed");

    // A pad level transaction shows up as the stored pad level next cycle.
    a_pad_level: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_PAD
        |=> out_valid && in_from_pad == $past(pad_level))
        else $error("pad level not stored");

    // A driven pin reports the driven level as its state.
    a_driven_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oe_to_pad |-> pin_state == {2'b00, out_to_pad})
        else $error("driven pin state mismatch");

    // An undriven pin is one of the input classes.
    a_undriven_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !oe_to_pad |->
            pin_state == PIN_INPUT || pin_state == PIN_PULLDOWN ||
            pin_state == PIN_PULLUP || pin_state == PIN_KEEPER)
        else $error("undriven pin state out of class");

    // The two level status bits are never set together.
    a_level_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(irq_status_bits[0] && irq_status_bits[1]))
        else $error("both level bits set");

endmodule

bind gpio_pin_override_and_irq_top gpio_ovr_checker u_gpio_ovr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .pad_level       (pad_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .in_from_pad     (in_from_pad),
    .oe_to_pad       (oe_to_pad),
    .out_to_pad      (out_to_pad),
    .pin_state       (pin_state),
    .irq_status_bits (irq_status_bits)
);

/* tb/tb.sv */
// ============================================================================
// tb
// Self-checking bench for the single-pin GPIO override and interrupt block.
// A directed script covers reset behavior, every interrupt status update,
// every function select route and every override mode. Random phases follow,
// each with its own configuration. Results are compared field by field
// against an in-bench model of the pin.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gpio_ovr_pkg::*;

    // The kind value that the block defines no action for. It must leave all
    // pin state alone, just like a refresh.
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam logic [4:0] FSEL_UNROUTED = 5'd0;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL   = 300;   // last items run with no idling
    localparam int LONG_HOLD    = 150;   // receiver hold-off, in cycles

    // One input transaction. The bit order matches the port concatenation
    // used by the driver and the monitor.
    typedef struct packed {
        logic [1:0] kind;
        logic       pad_level;
        logic [3:0] ack_mask;
        logic       pwm_oe;
        logic       pwm_out;
        logic       sio_oe;
        logic       sio_out;
        logic       pio0_oe;
        logic       pio0_out;
        logic       pio1_oe;
        logic       pio1_out;
    } pin_item_t;

    // A script row may reprogram the pin before its transaction. Where the
    // answer is obvious from the reset configuration it is typed in.
    typedef struct {
        bit        cfg_first;
        cfg_t      cfg;
        pin_item_t item;
        bit        typed;
        result_t   res;
    } script_row_t;

    // Travels alongside each offered transaction so that the monitor knows
    // whether to use a typed answer or the model's prediction.
    typedef struct {
        bit      typed;
        result_t res;
    } answer_t;

    localparam cfg_t NO_CFG = '0;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [1:0]          kind      = KIND_REFRESH;
    logic                pad_level = 1'b0;
    logic [3:0]          ack_mask  = '0;
    logic                pwm_oe    = 1'b0;
    logic                pwm_out   = 1'b0;
    logic                sio_oe    = 1'b0;
    logic                sio_out   = 1'b0;
    logic                pio0_oe   = 1'b0;
    logic                pio0_out  = 1'b0;
    logic                pio1_oe   = 1'b0;
    logic                pio1_out  = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    logic                irq_to_proc;
    logic                irq_from_pad;
    logic                in_to_peri;
    logic                in_from_pad;
    logic                oe_to_pad;
    logic                oe_from_peri;
    logic                out_to_pad;
    logic                out_from_peri;
    logic [2:0]          pin_state;
    logic                pin_state_changed;
    logic                irq_changed;
    logic [3:0]          irq_status_bits;

    gpio_pin_override_and_irq_top dut (.*);

    // Model of the pin: its configuration copy and its three state items.
    cfg_t       pin_cfg    = '{FSEL_RESET, OVR_PASS, OVR_PASS, OVR_PASS, OVR_PASS,
                               PAD_RESET, 4'h0, 4'h0};
    logic       pad_seen   = 1'b0;
    logic [3:0] irq_stat   = 4'h0;
    logic [2:0] prev_state = PIN_INPUT;

    result_t owed_results[$];   // predicted results not yet seen at the output
    answer_t table_answers[$];  // answer source for each offered transaction

    int  fail_count   = 0;
    int  accepted     = 0;
    int  checked      = 0;
    int  reg_writes   = 0;
    bit  sender_bursts   = 1'b0;
    bit  receiver_bursts = 1'b0;
    bit  hold_request    = 1'b0;

    // ------------------------------------------------------------------------
    // Clock, and a watchdog that ends a hung run.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("tb: timeout with %0d results still pending", owed_results.size());
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pin model.
    // ------------------------------------------------------------------------
    function automatic logic mode_apply(input logic v, input ovr_mode_t mode);
        case (mode)
            OVR_INVERT: return ~v;
            OVR_LOW:    return 1'b0;
            OVR_HIGH:   return 1'b1;
            default:    return v;
        endcase
    endfunction

    function automatic logic irq_line();
        return |((irq_stat & pin_cfg.irq_enable_mask) | pin_cfg.irq_force_mask);
    endfunction

    // Updates the model state for one transaction and returns its result.
    function automatic result_t predict_pin(input pin_item_t it);
        result_t r;
        logic    in_en;
        logic    irq_before;
        logic    sel_oe;
        logic    sel_out;
        logic    pd;
        logic    pu;

        in_en      = pin_cfg.pad_control[PAD_INEN_BIT];
        irq_before = mode_apply(irq_line(), pin_cfg.irq_override);

        // A pad event always restates the level bits and sets an edge bit,
        // even when the level did not move. A disabled input reads as low.
        case (it.kind)
            KIND_PAD:
            begin
                pad_seen = it.pad_level;
                if (it.pad_level && in_en)
                    irq_stat = (irq_stat | STAT_EDGE_HI | STAT_LVL_HI) & ~STAT_LVL_LO;
                else
                    irq_stat = (irq_stat | STAT_EDGE_LO | STAT_LVL_LO) & ~STAT_LVL_HI;
            end
            KIND_ACK:
                irq_stat = irq_stat & ~(it.ack_mask & (STAT_EDGE_LO | STAT_EDGE_HI));
            default:
                ;
        endcase

        case (pin_cfg.function_select)
            FSEL_PWM:  begin sel_oe = it.pwm_oe;  sel_out = it.pwm_out;  end
            FSEL_SIO:  begin sel_oe = it.sio_oe;  sel_out = it.sio_out;  end
            FSEL_PIO0: begin sel_oe = it.pio0_oe; sel_out = it.pio0_out; end
            FSEL_PIO1: begin sel_oe = it.pio1_oe; sel_out = it.pio1_out; end
            default:   begin sel_oe = 1'b0;       sel_out = 1'b0;        end
        endcase

        r.oe_from_peri    = sel_oe;
        r.out_from_peri   = sel_out;
        r.oe_to_pad       = mode_apply(sel_oe, pin_cfg.oe_override);
        r.out_to_pad      = mode_apply(sel_out, pin_cfg.output_override);
        r.in_from_pad     = pad_seen;
        r.in_to_peri      = mode_apply(pad_seen & in_en, pin_cfg.input_override);
        r.irq_from_pad    = irq_line();
        r.irq_to_proc     = mode_apply(r.irq_from_pad, pin_cfg.irq_override);
        r.irq_changed     = r.irq_to_proc != irq_before;
        r.irq_status_bits = irq_stat;

        // Driven pins follow the output. Otherwise the pulls decide, and both
        // pulls together hold the last level.
        pd = pin_cfg.pad_control[PAD_PULLDOWN_BIT];
        pu = pin_cfg.pad_control[PAD_PULLUP_BIT];
        if (r.oe_to_pad)
            r.pin_state = r.out_to_pad ? PIN_HIGH : PIN_LOW;
        else if (pd && pu)
            r.pin_state = PIN_KEEPER;
        else if (pd)
            r.pin_state = PIN_PULLDOWN;
        else if (pu)
            r.pin_state = PIN_PULLUP;
        else
            r.pin_state = PIN_INPUT;
        r.pin_state_changed = r.pin_state != prev_state;
        prev_state = r.pin_state;
        return r;
    endfunction

    // Register writes are masked to the register width; indexes beyond the
    // register list do nothing.
    task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
        case (idx)
            REG_FUNCSEL:    pin_cfg.function_select = d[4:0];
            REG_OUT_OVR:    pin_cfg.output_override = ovr_mode_t'(d[1:0]);
            REG_OE_OVR:     pin_cfg.oe_override     = ovr_mode_t'(d[1:0]);
            REG_IN_OVR:     pin_cfg.input_override  = ovr_mode_t'(d[1:0]);
            REG_IRQ_OVR:    pin_cfg.irq_override    = ovr_mode_t'(d[1:0]);
            REG_PAD_CTRL:   pin_cfg.pad_control     = d;
            REG_IRQ_ENABLE: pin_cfg.irq_enable_mask = d[3:0];
            REG_IRQ_FORCE:  pin_cfg.irq_force_mask  = d[3:0];
            default:        ;
        endcase
    endtask

    // Expected result under the reset configuration: nothing is routed, the
    // pad only pulls down and no interrupt is enabled.
    function automatic result_t at_reset(input logic in_peri, input logic in_pad,
                                         input logic moved, input logic [3:0] stat);
        return {1'b0, 1'b0, in_peri, in_pad, 4'b0000, PIN_PULLDOWN, moved, 1'b0, stat};
    endfunction

    function automatic string field_diffs(input result_t e, input result_t a);
        string s;
        s = "";
        if (e.irq_to_proc       != a.irq_to_proc)       s = {s, " irq_to_proc"};
        if (e.irq_from_pad      != a.irq_from_pad)      s = {s, " irq_from_pad"};
        if (e.in_to_peri        != a.in_to_peri)        s = {s, " in_to_peri"};
        if (e.in_from_pad       != a.in_from_pad)       s = {s, " in_from_pad"};
        if (e.oe_to_pad         != a.oe_to_pad)         s = {s, " oe_to_pad"};
        if (e.oe_from_peri      != a.oe_from_peri)      s = {s, " oe_from_peri"};
        if (e.out_to_pad        != a.out_to_pad)        s = {s, " out_to_pad"};
        if (e.out_from_peri     != a.out_from_peri)     s = {s, " out_from_peri"};
        if (e.pin_state         != a.pin_state)         s = {s, " pin_state"};
        if (e.pin_state_changed != a.pin_state_changed) s = {s, " pin_state_changed"};
        if (e.irq_changed       != a.irq_changed)       s = {s, " irq_changed"};
        if (e.irq_status_bits   != a.irq_status_bits)   s = {s, " irq_status_bits"};
        return s;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("tb: ERROR %s", what);
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge. The output side is
    // handled first, so that a stray result can never be matched against the
    // transaction accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : pin_monitor
        result_t   act;
        result_t   want;
        pin_item_t seen;
        answer_t   ans;
        string     diffs;

        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                act = {irq_to_proc, irq_from_pad, in_to_peri, in_from_pad, oe_to_pad,
                       oe_from_peri, out_to_pad, out_from_peri, pin_state,
                       pin_state_changed, irq_changed, irq_status_bits};
                if (owed_results.size() == 0)
                    log_failure($sformatf("result %p arrived with nothing pending", act));
                else
                begin
                    want  = owed_results.pop_front();
                    diffs = field_diffs(want, act);
                    if (diffs != "")
                        log_failure($sformatf("result %0d wrong in%s: expected %p, got %p",
                                              checked, diffs, want, act));
                    checked++;
                end
            end

            if (in_valid && in_ready)
            begin
                seen = {kind, pad_level, ack_mask, pwm_oe, pwm_out, sio_oe, sio_out,
                        pio0_oe, pio0_out, pio1_oe, pio1_out};
                want = predict_pin(seen);
                ans  = table_answers.pop_front();
                owed_results.push_back(ans.typed ? ans.res : want);
                accepted++;
            end

            if (cfg_we)
                apply_reg(cfg_index, cfg_wdata);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Inputs change at the falling edge. It stalls in random bursts
    // while enabled, and once on request it holds off for a long stretch so
    // that the result register stays full and the input side backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (receiver_bursts && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one transaction, possibly after an idle burst, and returns at the
    // rising edge where it is accepted. Valid stays high between back-to-back
    // transactions.
    task automatic offer_item(input pin_item_t it, input bit typed, input result_t res);
        table_answers.push_back('{typed, res});
        @(negedge clk);
        if (sender_bursts && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        {kind, pad_level, ack_mask, pwm_oe, pwm_out, sio_oe, sio_out,
         pio0_oe, pio0_out, pio1_oe, pio1_out} <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every predicted result has come out.
    // Every transaction produces exactly one result, so an empty queue means
    // the block is idle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge clk);
    endtask

    // Writes all eight registers, with junk above each register's width, and
    // one write to an index past the register list that must be ignored.
    task automatic program_pin(input cfg_t c);
        logic [7:0] junk;

        junk = 8'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FUNCSEL;
        cfg_wdata <= {junk[7:5], c.function_select};
        @(negedge clk);
        cfg_index <= REG_OUT_OVR;
        cfg_wdata <= {junk[5:0], c.output_override};
        @(negedge clk);
        cfg_index <= REG_OE_OVR;
        cfg_wdata <= {junk[6:1], c.oe_override};
        @(negedge clk);
        cfg_index <= REG_IN_OVR;
        cfg_wdata <= {junk[7:2], c.input_override};
        @(negedge clk);
        cfg_index <= REG_IRQ_OVR;
        cfg_wdata <= {~junk[5:0], c.irq_override};
        @(negedge clk);
        cfg_index <= REG_PAD_CTRL;
        cfg_wdata <= c.pad_control;
        @(negedge clk);
        cfg_index <= REG_IRQ_ENABLE;
        cfg_wdata <= {junk[3:0], c.irq_enable_mask};
        @(negedge clk);
        cfg_index <= REG_IRQ_FORCE;
        cfg_wdata <= {junk[7:4], c.irq_force_mask};
        @(negedge clk);
        cfg_index <= 4'($urandom_range(8, 15));
        cfg_wdata <= 8'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes += 9;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        script_row_t script[$];
        pin_item_t   it;
        cfg_t        c;
        int          sent;
        int          phase;
        int          span;
        int          pick;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: unrouted, pull-down pad with input enabled,
        // no interrupt enables. The first refresh sees the pin leave the
        // plain input class it had at reset.
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_REFRESH, 1'b0, 4'h0, 8'h00}),
                           1'b1, at_reset(1'b0, 1'b0, 1'b1, 4'b0000)});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b1, 4'h0, 8'h00}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b1010)});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b0, 4'h0, 8'h00}),
                           1'b1, at_reset(1'b0, 1'b0, 1'b0, 4'b1101)});
        // Acknowledge bits outside the edge bits do nothing.
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b0, 4'b0011, 8'h00}),
                           1'b1, at_reset(1'b0, 1'b0, 1'b0, 4'b1101)});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b1, 4'b1111, 8'hff}),
                           1'b1, at_reset(1'b0, 1'b0, 1'b0, 4'b0001)});
        // Peripheral bits are ignored while the pin is unrouted.
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b1, 4'hf, 8'hff}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b1010)});
        // The spare kind changes nothing, whatever its other fields say.
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_SPARE, 1'b0, 4'hf, 8'h00}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b1010)});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b0, 4'b0100, 8'h00}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b1010)});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b0, 4'b1000, 8'h00}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b0010)});
        // A repeated high level sets the edge bit again.
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b1, 4'h0, 8'h00}),
                           1'b1, at_reset(1'b1, 1'b1, 1'b0, 4'b1010)});

        // Each route and each override mode, checked by the model. PWM with
        // both pulls on lands in the bus keeper class once undriven.
        script.push_back('{1'b1, cfg_t'{FSEL_PWM, OVR_PASS, OVR_PASS, OVR_PASS, OVR_PASS,
                           8'h4c, 4'hf, 4'h0},
                           pin_item_t'({KIND_REFRESH, 1'b0, 4'h0, 8'b1100_0000}), 1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b0, 4'h0, 8'b0100_0000}),
                           1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b0, 4'hc, 8'b1000_0000}),
                           1'b0, '0});
        // SIO with everything inverted and the input disabled, so a high pad
        // level still counts as a low edge.
        script.push_back('{1'b1, cfg_t'{FSEL_SIO, OVR_INVERT, OVR_INVERT, OVR_INVERT,
                           OVR_INVERT, 8'h08, 4'h4, 4'h0},
                           pin_item_t'({KIND_REFRESH, 1'b0, 4'h0, 8'b1100_1111}), 1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b1, 4'h0, 8'b0011_0000}),
                           1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b1, 4'hc, 8'b1110_0000}),
                           1'b0, '0});
        // PIO0 with forced values; output disable has no effect.
        script.push_back('{1'b1, cfg_t'{FSEL_PIO0, OVR_LOW, OVR_HIGH, OVR_LOW, OVR_LOW,
                           8'hc0, 4'h0, 4'h8},
                           pin_item_t'({KIND_PAD, 1'b1, 4'h0, 8'b0000_1100}), 1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_REFRESH, 1'b0, 4'h0, 8'b1111_0011}),
                           1'b0, '0});
        // PIO1 with every other register at its maximum.
        script.push_back('{1'b1, cfg_t'{FSEL_PIO1, OVR_HIGH, OVR_HIGH, OVR_HIGH, OVR_HIGH,
                           8'hff, 4'hf, 4'hf},
                           pin_item_t'({KIND_PAD, 1'b0, 4'h0, 8'b0000_0000}), 1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_ACK, 1'b0, 4'hf, 8'b0000_0011}),
                           1'b0, '0});
        // Every register at zero: unrouted, plain input, nothing enabled.
        script.push_back('{1'b1, cfg_t'{FSEL_UNROUTED, OVR_PASS, OVR_PASS, OVR_PASS,
                           OVR_PASS, 8'h00, 4'h0, 4'h0},
                           pin_item_t'({KIND_REFRESH, 1'b0, 4'h0, 8'hff}), 1'b0, '0});
        script.push_back('{1'b0, NO_CFG, pin_item_t'({KIND_PAD, 1'b1, 4'h0, 8'hff}),
                           1'b0, '0});

        foreach (script[i])
        begin
            if (script[i].cfg_first)
            begin
                wait_idle();
                program_pin(script[i].cfg);
            end
            offer_item(script[i].item, script[i].typed, script[i].res);
        end

        // Random phases. The first two use the all-low and all-high settings,
        // the rest random ones, favoring routed selects and a quiet force
        // mask so that the status bits drive the interrupt most of the time.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
                c = '{FSEL_UNROUTED, OVR_PASS, OVR_PASS, OVR_PASS, OVR_PASS,
                      8'h00, 4'h0, 4'h0};
            else if (phase == 1)
                c = '{FSEL_RESET, OVR_HIGH, OVR_HIGH, OVR_HIGH, OVR_HIGH,
                      8'hff, 4'hf, 4'hf};
            else
            begin
                c.function_select = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                : 5'(FSEL_PWM + $urandom_range(0, 3));
                c.output_override = ovr_mode_t'($urandom_range(0, 3));
                c.oe_override     = ovr_mode_t'($urandom_range(0, 3));
                c.input_override  = ovr_mode_t'($urandom_range(0, 3));
                c.irq_override    = ovr_mode_t'($urandom_range(0, 3));
                c.pad_control     = 8'($urandom);
                c.irq_enable_mask = 4'($urandom);
                c.irq_force_mask  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15))
                                                                : 4'h0;
            end

            wait_idle();
            program_pin(c);

            // Idling comes and goes per phase and stops near the end.
            sender_bursts   = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            receiver_bursts = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (phase == 3)
                hold_request = 1'b1;

            span = $urandom_range(40, 160);
            repeat (span)
            begin
                pick = $urandom_range(0, 19);
                it = pin_item_t'(15'($urandom));
                if (pick < 9)
                    it.kind = KIND_PAD;
                else if (pick < 15)
                    it.kind = KIND_ACK;
                else if (pick < 19)
                    it.kind = KIND_REFRESH;
                else
                    it.kind = KIND_SPARE;
                offer_item(it, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        // Drain, then leave the block idle so that any stray result shows before
        // the verdict.
        wait_idle();
        repeat (4) @(negedge clk);
        if (owed_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", owed_results.size()));

        $display("tb: %0d transactions accepted, %0d results compared, %0d register writes",
                 accepted, checked, reg_writes);
        $display("tb: %0d directed rows and %0d random phases, %0d failures",
                 script.size(), phase, fail_count);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
